// ===== hw/rtl/aabb_pkg.sv =====
// Shared types, constants and helper functions for the pairwise box collision block.
`timescale 1ns / 1ps

package aabb_pkg;

    // Default store depth and fixed limits
    localparam int MAX_BOXES_DEF = 16;
    localparam int NUM_TAGS      = 16;
    localparam int MAX_RESULTS   = 15;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);

    // Stream widths (fields packed from bit 0 up, padded to whole bytes)
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 80;

    // Operation codes carried on the input tuser
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    typedef enum logic [1:0] {
        SIDE_LEFT  = 2'd0,
        SIDE_UP    = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_DOWN  = 2'd3
    } side_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_FLUSH,
        ST_FULL
    } state_t;

    // Input item; last member sits in the lowest bits
    typedef struct packed {
        logic [15:0]        ignore_mask;
        logic [3:0]         tag_id;
        logic               bind_req;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
        logic [14:0]        box_h;
        logic [14:0]        box_w;
        logic signed [15:0] off_y;
        logic signed [15:0] off_x;
    } in_item_t;

    localparam int IN_ITEM_W = $bits(in_item_t);

    // One stored box
    typedef struct packed {
        logic signed [16:0] left;
        logic signed [16:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [3:0]         tag;
        logic [15:0]        ign;
    } box_t;

    // Box under test with its far edges
    typedef struct packed {
        box_t               box;
        logic signed [17:0] right;
        logic signed [17:0] bottom;
    } new_box_t;

    // Result item; last member sits in the lowest bits
    typedef struct packed {
        logic               notify_new;
        logic               notify_earlier;
        logic [14:0]        inter_h;
        logic [14:0]        inter_w;
        logic signed [15:0] inter_y;
        logic signed [15:0] inter_x;
        side_t              earlier_side;
        logic [3:0]         new_index;
        logic [3:0]         earlier_index;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Sequencer to pair unit
    typedef struct packed {
        logic adv;
        logic issue;
    } pair_ctrl_t;

    // Pair unit to sequencer
    typedef struct packed {
        logic busy;
        logic hit;
    } pair_stat_t;

    // Clamp a 17-bit signed value into 16 bits
    function automatic logic [15:0] sat_s16(input logic [16:0] v);
        logic [15:0] r;
        if (v[16] != v[15]) begin
            r = v[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Tag lookup in an ignore mask; tags beyond the tag range are never ignored
    function automatic logic ignores(input logic [15:0] mask, input logic [3:0] tag);
        logic r;
        r = (int'(tag) < NUM_TAGS) && mask[tag];
        return r;
    endfunction

endpackage

// ===== hw/rtl/aabb_pairwise_collision.sv =====
// Top level of the pairwise box collision block: sequencer, pending result and output register.
//
// Input channel (s_axis): tuser carries the operation (clear or add), tdata the box.
// A clear empties the store and produces no result. An add places the box at its
// offset (plus the position when bind_req is set), stores it and tests it against
// every earlier stored box in slot order. Each overlap, up to 15 per add, yields one result
// transfer on m_axis with the intersection rectangle, side and notify flags; tlast marks the
// final result of that add. An add that finds no overlap produces no transfer. An add
// into a full store produces a single transfer with tuser (table_full) set.
// Steps of an add against stored boxes: the transfer, one store write, one memory read per
// stored box, three compare stages, a check that the pipe has drained and a flush of the
// held result. An add into an empty store has no reads or compares, a refused add goes
// to the table_full transfer and a clear only empties the store. The memory read port sets
// the scan rate of one stored box per cycle while the scan is not stalled.
// s_axis_tready is high only while no add is in progress.
// When m_axis_tready is low, the scan freezes once a result has nowhere to go; no
// result is lost. Reset empties the store and drops any result in flight.
`timescale 1ns / 1ps

module aabb_pairwise_collision #(
    parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_axis_tdata: off_x, off_y, box_w, box_h, pos_x, pos_y, bind_req, tag_id,
    //               ignore_mask, zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [aabb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: operation
    input  logic                             s_axis_tuser,
    // m_axis_tdata: earlier_index, new_index, earlier_side, inter_x, inter_y,
    //               inter_w, inter_h, notify_earlier, notify_new, zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [aabb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // m_axis_tuser: table_full
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import aabb_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [RES_W-1:0] res_cnt_reg, res_cnt_next;
    new_box_t         nbox_reg, nbox_next;

    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg, pend_next;

    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_full_reg, m_full_next;

    in_item_t         in_item;
    logic signed [16:0] in_left, in_top;
    logic             out_free, take, stall;
    logic             mem_we;
    pair_ctrl_t       ctrl;
    pair_stat_t       stat;
    box_t             rd_box;
    result_t          pair_result;

    assign in_item = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);

    // Place the incoming box
    always_comb begin
        in_left = {in_item.off_x[15], in_item.off_x};
        in_top  = {in_item.off_y[15], in_item.off_y};
        if (in_item.bind_req) begin
            in_left = in_left + {in_item.pos_x[15], in_item.pos_x};
            in_top  = in_top + {in_item.pos_y[15], in_item.pos_y};
        end
    end

    aabb_box_mem #(
        .MAX_BOXES(MAX_BOXES)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (slot_reg),
        .wr_data (nbox_reg.box),
        .rd_en   (ctrl.adv),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_box)
    );

    aabb_pair_unit #(
        .MAX_BOXES(MAX_BOXES)
    ) u_pair (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .rd_idx  (rd_idx_reg),
        .rd_box  (rd_box),
        .nbox    (nbox_reg),
        .slot    (slot_reg),
        .stat    (stat),
        .result  (pair_result)
    );

    // Sequencer, pending result and output register
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        rd_idx_next     = rd_idx_reg;
        res_cnt_next    = res_cnt_reg;
        nbox_next       = nbox_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_full_next     = m_full_reg;
        mem_we          = 1'b0;
        s_axis_tready   = (state_reg == ST_IDLE);

        out_free   = !m_valid_reg || m_axis_tready;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        // Hits beyond the result limit are dropped
        take       = stat.hit && (res_cnt_reg < RES_W'(MAX_RESULTS));
        stall      = take && pend_valid_reg && !out_free;
        ctrl.adv   = !stall;
        ctrl.issue = (state_reg == ST_SCAN) && (rd_idx_reg < slot_reg);

        // Move a new hit into the pending slot, pushing the older one out
        if (take && !stall) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = pend_reg;
                m_last_next  = 1'b0;
                m_full_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = pair_result;
            res_cnt_next    = res_cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_CLEAR) begin
                        count_next = '0;
                    end else if (count_reg == CNT_W'(MAX_BOXES)) begin
                        state_next = ST_FULL;
                    end else begin
                        nbox_next.box.left   = in_left;
                        nbox_next.box.top    = in_top;
                        nbox_next.box.width  = in_item.box_w;
                        nbox_next.box.height = in_item.box_h;
                        nbox_next.box.tag    = in_item.tag_id;
                        nbox_next.box.ign    = in_item.ignore_mask;
                        slot_next            = count_reg[IDX_W-1:0];
                        rd_idx_next          = '0;
                        res_cnt_next         = '0;
                        state_next           = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                // Store the box and form its far edges
                nbox_next.right  = {nbox_reg.box.left[16], nbox_reg.box.left}
                                   + {3'b000, nbox_reg.box.width};
                nbox_next.bottom = {nbox_reg.box.top[16], nbox_reg.box.top}
                                   + {3'b000, nbox_reg.box.height};
                mem_we           = 1'b1;
                count_next       = count_reg + 1'b1;
                state_next       = ST_SCAN;
            end
            ST_SCAN: begin
                if (ctrl.issue && ctrl.adv) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (!ctrl.issue && !stat.busy) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // Release the held result as the last one
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = pend_reg;
                    m_last_next     = 1'b1;
                    m_full_next     = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_FULL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    m_full_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        nbox_reg   <= nbox_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_full_reg <= m_full_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - RESULT_W)'(0), m_data_reg};
    assign m_axis_tuser  = m_full_reg;
    assign m_axis_tlast  = m_last_reg;

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !pend_valid_reg)
        else $error("held result while taking input");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count past store depth");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> rd_idx_reg <= slot_reg)
        else $error("read index past new slot");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_full_reg |-> m_last_reg && (m_data_reg == '0))
        else $error("table_full result not clean");

    a_res_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RES_W'(MAX_RESULTS))
        else $error("result count past limit");

endmodule

// ===== hw/rtl/aabb_box_mem.sv =====
// Box store: one write port, one registered read port.
`timescale 1ns / 1ps

module aabb_box_mem #(
    parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_BOXES)-1:0] wr_addr,
    input  aabb_pkg::box_t               wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_BOXES)-1:0] rd_addr,
    output aabb_pkg::box_t               rd_data
);
    import aabb_pkg::*;

    box_t mem [MAX_BOXES];
    box_t rd_data_reg;

    // Write the new box
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold data while the scan is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/aabb_pair_unit.sv =====
// Three-stage overlap test and intersection builder for one stored box per cycle while not stalled.
`timescale 1ns / 1ps

module aabb_pair_unit #(
    parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  aabb_pkg::pair_ctrl_t         ctrl,
    input  logic [$clog2(MAX_BOXES)-1:0] rd_idx,
    input  aabb_pkg::box_t               rd_box,
    input  aabb_pkg::new_box_t           nbox,
    input  logic [$clog2(MAX_BOXES)-1:0] slot,
    output aabb_pkg::pair_stat_t         stat,
    output aabb_pkg::result_t            result
);
    import aabb_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);

    // Stage 1: memory data valid
    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;

    // Stage 2: overlap found, near edges chosen
    logic               v2_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic signed [16:0] ix2_reg, iy2_reg;
    logic signed [17:0] er2_reg, eb2_reg;
    logic               xe2_reg, ye2_reg, ne2_reg, nn2_reg;

    // Stage 3: intersection size known
    logic               v3_reg;
    logic [IDX_W-1:0]   idx3_reg;
    logic signed [16:0] ix3_reg, iy3_reg;
    logic [14:0]        iw3_reg, ih3_reg;
    logic               xe3_reg, ye3_reg, ne3_reg, nn3_reg;

    // Stage 1 combinational
    logic signed [16:0] e_x, e_y, n_x, n_y;
    logic signed [17:0] e_x18, e_y18, n_x18, n_y18, e_right, e_bottom;
    logic               hit1, x_from_e, y_from_e;

    // Stage 2 combinational
    logic signed [17:0] min_r, min_b, w_full, h_full;

    // Stage 3 combinational
    side_t              side;

    // Compare the stored box against the new one
    always_comb begin
        e_x      = rd_box.left;
        e_y      = rd_box.top;
        n_x      = nbox.box.left;
        n_y      = nbox.box.top;
        e_x18    = {e_x[16], e_x};
        e_y18    = {e_y[16], e_y};
        n_x18    = {n_x[16], n_x};
        n_y18    = {n_y[16], n_y};
        e_right  = e_x18 + {3'b000, rd_box.width};
        e_bottom = e_y18 + {3'b000, rd_box.height};
        hit1     = v1_reg && (n_x18 < e_right) && (nbox.right > e_x18)
                   && (n_y18 < e_bottom) && (nbox.bottom > e_y18);
        x_from_e = (e_x >= n_x);
        y_from_e = (e_y >= n_y);
    end

    // Far edge and size of the intersection
    always_comb begin
        min_r  = (er2_reg < nbox.right) ? er2_reg : nbox.right;
        min_b  = (eb2_reg < nbox.bottom) ? eb2_reg : nbox.bottom;
        w_full = min_r - {ix2_reg[16], ix2_reg};
        h_full = min_b - {iy2_reg[16], iy2_reg};
    end

    // Valid bits of the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ctrl.adv) begin
            v1_reg <= ctrl.issue;
            v2_reg <= hit1;
            v3_reg <= v2_reg;
        end
    end

    // Stage payload; freeze on stall
    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            idx1_reg <= rd_idx;

            idx2_reg <= idx1_reg;
            ix2_reg  <= x_from_e ? e_x : n_x;
            iy2_reg  <= y_from_e ? e_y : n_y;
            er2_reg  <= e_right;
            eb2_reg  <= e_bottom;
            xe2_reg  <= x_from_e;
            ye2_reg  <= y_from_e;
            ne2_reg  <= !ignores(rd_box.ign, nbox.box.tag);
            nn2_reg  <= !ignores(nbox.box.ign, rd_box.tag);

            idx3_reg <= idx2_reg;
            ix3_reg  <= ix2_reg;
            iy3_reg  <= iy2_reg;
            iw3_reg  <= w_full[14:0];
            ih3_reg  <= h_full[14:0];
            xe3_reg  <= xe2_reg;
            ye3_reg  <= ye2_reg;
            ne3_reg  <= ne2_reg;
            nn3_reg  <= nn2_reg;
        end
    end

    // Pick the earlier box's side: narrow overlap means a left or right contact
    always_comb begin
        if (ih3_reg > iw3_reg) begin
            side = xe3_reg ? SIDE_RIGHT : SIDE_LEFT;
        end else begin
            side = ye3_reg ? SIDE_UP : SIDE_DOWN;
        end
    end

    // Assemble the result
    always_comb begin
        result.earlier_index  = 4'(idx3_reg);
        result.new_index      = 4'(slot);
        result.earlier_side   = side;
        result.inter_x        = sat_s16(ix3_reg);
        result.inter_y        = sat_s16(iy3_reg);
        result.inter_w        = iw3_reg;
        result.inter_h        = ih3_reg;
        result.notify_earlier = ne3_reg;
        result.notify_new     = nn3_reg;
    end

    assign stat.busy = v1_reg || v2_reg || v3_reg;
    assign stat.hit  = v3_reg;

    // A stage can only hold a hit if the stage before it did
    a_hit_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.adv && !v2_reg |=> !v3_reg)
        else $error("stage 3 valid without stage 2");

    a_no_issue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.adv && !ctrl.issue |=> !v1_reg)
        else $error("stage 1 valid without a read");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.adv |=> $stable(v3_reg) && $stable(iw3_reg))
        else $error("stage 3 moved during stall");

endmodule
